[hdl/kruskal_edge_acceptor_macros.svh]
// Assertion macros used by the checker file.
`ifndef KRUSKAL_EDGE_ACCEPTOR_MACROS_SVH
`define KRUSKAL_EDGE_ACCEPTOR_MACROS_SVH

// Checked only while out of reset.
`define KEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KEA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/kea_pkg.sv]
package kea_pkg;

  localparam int NODE_W      = 6;
  localparam int WEIGHT_W    = 32;
  localparam int TOTAL_W     = 40;
  localparam int CNT_W       = 6;
  localparam int CFG_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

  // decoded edge handed from front to back
  typedef struct packed {
    logic                start_graph;
    logic                in_range;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic [CFG_W-1:0]    lim_m1;
  } cmd_t;

  typedef struct packed {
    logic               edge_accepted;
    logic [TOTAL_W-1:0] tree_weight;
    logic               tree_complete;
    logic [CNT_W-1:0]   edges_taken;
  } res_t;

endpackage

[hdl/kea_fifo.sv]
module kea_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointers wrap naturally, DEPTH is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

[hdl/kea_front.sv]
module kea_front #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kea_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          start_graph,
  input  logic [kea_pkg::NODE_W-1:0]    node_a,
  input  logic [kea_pkg::NODE_W-1:0]    node_b,
  input  logic [kea_pkg::WEIGHT_W-1:0]  edge_weight,
  output kea_pkg::cmd_t                 cmd
);
  import kea_pkg::*;

  localparam logic [WEIGHT_W-1:0] WMASK = WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  logic [CFG_W-1:0] node_count_r;
  logic [CFG_W-1:0] eff_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // clamp node count into 1..MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      eff_n = CFG_W'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      eff_n = CFG_W'(MAX_NODES);
    end else begin
      eff_n = node_count_r;
    end
  end

  always_comb begin
    cmd.start_graph = start_graph;
    cmd.in_range    = ({1'b0, node_a} < eff_n) && ({1'b0, node_b} < eff_n);
    cmd.node_a      = node_a;
    cmd.node_b      = node_b;
    cmd.weight      = edge_weight & WMASK;
    cmd.lim_m1      = eff_n - CFG_W'(1);
  end

endmodule

[hdl/kea_back.sv]
module kea_back #(
  parameter int MAX_NODES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  kea_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output kea_pkg::res_t res
);
  import kea_pkg::*;

  // only nodes reachable by a 6-bit endpoint ever change label
  localparam int NCELL = (MAX_NODES < (2 ** NODE_W)) ? MAX_NODES : (2 ** NODE_W);
  localparam int LW    = $clog2(NCELL);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic               st_r;
  cmd_t               cmd_r;
  logic [LW-1:0]      label_r [NCELL];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W:0]   sum;
  logic [LW-1:0]      la, lb;
  logic               take, accept;

  assign take    = (st_r == ST_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop = take;

  assign la     = label_r[cmd_r.node_a[LW-1:0]];
  assign lb     = label_r[cmd_r.node_b[LW-1:0]];
  assign accept = cmd_r.in_range && ({1'b0, count_r} < cmd_r.lim_m1) && (la != lb);

  assign sum       = {1'b0, total_r} + (TOTAL_W + 1)'(cmd_r.weight);
  assign count_nxt = count_r + CNT_W'(accept);

  always_comb begin
    if (!accept) begin
      total_nxt = total_r;
    end else if (sum[TOTAL_W]) begin
      total_nxt = '1;
    end else begin
      total_nxt = sum[TOTAL_W-1:0];
    end
  end

  assign res_push          = (st_r == ST_APPLY);
  assign res.edge_accepted = accept;
  assign res.tree_weight   = total_nxt;
  assign res.tree_complete = ({1'b0, count_nxt} >= cmd_r.lim_m1);
  assign res.edges_taken   = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
      total_r <= '0;
      for (int i = 0; i < NCELL; i++) label_r[i] <= LW'(i);
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (take) begin
            st_r <= ST_APPLY;
            // new graph: clear before the lookup in the next cycle
            if (cmd.start_graph) begin
              count_r <= '0;
              total_r <= '0;
              for (int i = 0; i < NCELL; i++) label_r[i] <= LW'(i);
            end
          end
        end
        ST_APPLY: begin
          st_r    <= ST_IDLE;
          count_r <= count_nxt;
          total_r <= total_nxt;
          if (accept) begin
            for (int i = 0; i < NCELL; i++) begin
              if (label_r[i] == lb) label_r[i] <= la;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) cmd_r <= cmd;
  end

endmodule

[hdl/kruskal_edge_acceptor.sv]
// Kruskal spanning-tree edge acceptor. Push edges in ascending weight order;
// each edge yields one result (accepted flag, running total, complete flag,
// count) in push order. in_start_graph clears labels, count and total before
// its own edge. The node count written on cfg_wr_data takes effect for later
// edges and may only be written with no edge in flight. The back end holds one
// edge at a time and takes a new one only while the output queue has room: in
// ST_IDLE it loads the edge (and clears on start), and in ST_APPLY it looks up
// both labels and relabels the whole label array in parallel. Two-entry queues
// sit at the input and the output, and each edge passes from the input queue
// through the back end's cmd_r register into the output queue. Labels live in
// flops and are restored at reset, so no clearing pass is needed.
module kruskal_edge_acceptor #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kea_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_start_graph,
  input  logic [kea_pkg::NODE_W-1:0]    in_node_a,
  input  logic [kea_pkg::NODE_W-1:0]    in_node_b,
  input  logic [kea_pkg::WEIGHT_W-1:0]  in_edge_weight,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_edge_accepted,
  output logic [kea_pkg::TOTAL_W-1:0]   out_tree_weight,
  output logic                          out_tree_complete,
  output logic [kea_pkg::CNT_W-1:0]     out_edges_taken
);
  import kea_pkg::*;

  cmd_t cmd_in, cmd_q;
  res_t res_in, res_q;
  logic cmd_empty, cmd_pop;
  logic res_full, res_push;

  kea_front #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start_graph (in_start_graph),
    .node_a      (in_node_a),
    .node_b      (in_node_b),
    .edge_weight (in_edge_weight),
    .cmd         (cmd_in)
  );

  kea_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_q),
    .empty (cmd_empty)
  );

  kea_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  kea_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign out_edge_accepted = res_q.edge_accepted;
  assign out_tree_weight   = res_q.tree_weight;
  assign out_tree_complete = res_q.tree_complete;
  assign out_edges_taken   = res_q.edges_taken;

endmodule

[hdl/kea_checker.sv]
`include "kruskal_edge_acceptor_macros.svh"

module kea_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic                          out_edge_accepted,
  input logic [kea_pkg::TOTAL_W-1:0]   out_tree_weight,
  input logic                          out_tree_complete,
  input logic [kea_pkg::CNT_W-1:0]     out_edges_taken
);

  // both queues come out of reset drained
  `KEA_ASSERT_ALWAYS(a_reset_drains, !rst_n |=> (empty && !full), "queues not empty after reset")

  // the input queue only fills through a transfer
  `KEA_ASSERT(a_full_after_push, $rose(full) |-> $past(push), "full rose without a push")

  // an accepted edge is always counted
  `KEA_ASSERT(a_accept_counted, (!empty && out_edge_accepted) |-> (out_edges_taken != '0), "accepted edge with zero count")

  // a waiting result holds until transferred
  `KEA_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(out_edge_accepted) && $stable(out_tree_weight) && $stable(out_tree_complete) && $stable(out_edges_taken)), "waiting result changed")

endmodule

bind kruskal_edge_acceptor kea_checker u_kea_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .push              (push),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_edge_accepted (out_edge_accepted),
  .out_tree_weight   (out_tree_weight),
  .out_tree_complete (out_tree_complete),
  .out_edges_taken   (out_edges_taken)
);

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kea_pkg::*;

  localparam longint unsigned TREE_MAX = 64'h0000_00FF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic push = 1'b0;
  logic full;
  logic in_start_graph = 1'b0;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic [WEIGHT_W-1:0] in_edge_weight = '0;
  logic empty;
  logic pop = 1'b0;
  logic out_edge_accepted;
  logic [TOTAL_W-1:0] out_tree_weight;
  logic out_tree_complete;
  logic [CNT_W-1:0] out_edges_taken;

  // shadow copy of the spanning-forest state
  logic [NODE_W-1:0] comp_of [64];
  int taken_cnt;
  longint unsigned tree_sum;
  logic [CFG_W-1:0] cfg_nodes;

  res_t edge_verdicts[$];

  int errors = 0;
  int cycles = 0;
  int edges_sent = 0;
  int results_seen = 0;
  int joins_seen = 0;
  int trees_done = 0;
  int stall_cycles = 0;
  int rx_hold = 0;
  bit tx_rush = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  kruskal_edge_acceptor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .push              (push),
    .full              (full),
    .in_start_graph    (in_start_graph),
    .in_node_a         (in_node_a),
    .in_node_b         (in_node_b),
    .in_edge_weight    (in_edge_weight),
    .empty             (empty),
    .pop               (pop),
    .out_edge_accepted (out_edge_accepted),
    .out_tree_weight   (out_tree_weight),
    .out_tree_complete (out_tree_complete),
    .out_edges_taken   (out_edges_taken)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               edge_verdicts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (push && full) stall_cycles <= stall_cycles + 1;
  end

  function automatic void clear_forest();
    foreach (comp_of[i]) comp_of[i] = NODE_W'(i);
    taken_cnt = 0;
    tree_sum = 0;
  endfunction

  function automatic int live_nodes();
    if (cfg_nodes == 0) return 1;
    if (cfg_nodes > 64) return 64;
    return int'(cfg_nodes);
  endfunction

  function automatic res_t spanning_step(logic start, logic [NODE_W-1:0] a,
                                         logic [NODE_W-1:0] b, logic [WEIGHT_W-1:0] w);
    res_t r;
    int n;
    logic [NODE_W-1:0] la;
    logic [NODE_W-1:0] lb;
    r = '0;
    if (start) clear_forest();
    n = live_nodes();
    if (taken_cnt < n - 1 && int'(a) < n && int'(b) < n) begin
      la = comp_of[a];
      lb = comp_of[b];
      if (la != lb) begin
        r.edge_accepted = 1'b1;
        foreach (comp_of[i]) if (comp_of[i] == lb) comp_of[i] = la;
        taken_cnt++;
        if (longint'(w) > TREE_MAX - tree_sum) tree_sum = TREE_MAX;
        else tree_sum += w;
      end
    end
    r.tree_weight = tree_sum[TOTAL_W-1:0];
    r.tree_complete = (taken_cnt >= n - 1);
    r.edges_taken = (taken_cnt > 63) ? CNT_W'(63) : CNT_W'(taken_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on result %0d, %s: got 0x%0h, want 0x%0h", results_seen, field,
             got, want);
    errors++;
  endtask

  // call at a rising edge; returns at the edge of the transfer with push still high
  task automatic send_edge(logic start, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                           logic [WEIGHT_W-1:0] w);
    int gap;
    res_t verdict;
    if (edges_sent % 24 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = (tx_burst || tx_rush) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_start_graph <= start;
    in_node_a <= a;
    in_node_b <= b;
    in_edge_weight <= w;
    do @(negedge clk); while (full);
    verdict = spanning_step(start, a, b, w);
    edge_verdicts.insert(edge_verdicts.size(), verdict);
    edges_sent++;
    @(posedge clk);
  endtask

  task automatic wait_for_quiet();
    push <= 1'b0;
    while (edge_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_node_count(logic [CFG_W-1:0] value);
    wait_for_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_nodes = value;
  endtask

  // result side: random pop gaps, plus a long hold when requested
  initial begin : result_checker
    int gap;
    res_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (results_seen % 20 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (rx_hold > 0) begin
        gap = gap + rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(negedge clk); while (empty);
      if (edge_verdicts.size() == 0) begin
        $display("result transfer with nothing outstanding");
        errors++;
      end else begin
        want = edge_verdicts.pop_front();
        if (out_edge_accepted !== want.edge_accepted)
          report_mismatch("edge_accepted", out_edge_accepted, want.edge_accepted);
        if (out_tree_weight !== want.tree_weight)
          report_mismatch("tree_weight", out_tree_weight, want.tree_weight);
        if (out_tree_complete !== want.tree_complete)
          report_mismatch("tree_complete", out_tree_complete, want.tree_complete);
        if (out_edges_taken !== want.edges_taken)
          report_mismatch("edges_taken", out_edges_taken, want.edges_taken);
        if (want.edge_accepted) joins_seen++;
        if (want.edge_accepted && want.tree_complete) trees_done++;
      end
      results_seen++;
      @(posedge clk);
    end
  end

  // default node count, extreme weights and endpoints, rejections, start flag
  task automatic test_directed_edges();
    send_edge(1'b0, 6'd0, 6'd63, 32'hFFFF_FFFF);
    send_edge(1'b0, 6'd63, 6'd0, 32'hFFFF_FFFF);  // same component
    send_edge(1'b0, 6'd5, 6'd5, 32'h0000_0001);   // self loop
    send_edge(1'b0, 6'd1, 6'd62, 32'h0000_0000);
    send_edge(1'b0, 6'd62, 6'd0, 32'h8000_0000);  // merges two multi-node sets
    send_edge(1'b0, 6'd1, 6'd63, 32'h0001_0000);
    send_edge(1'b1, 6'd63, 6'd62, 32'h0000_0007); // clear before this edge
    send_edge(1'b0, 6'd0, 6'd63, 32'hFFFF_FFFF);
  endtask

  // node counts out of range, endpoints past the count, single node graphs
  task automatic test_node_count_limits();
    set_node_count(7'd4);
    send_edge(1'b1, 6'd0, 6'd5, 32'h0000_0010);   // endpoint past count
    send_edge(1'b0, 6'd4, 6'd0, 32'h0000_0011);
    send_edge(1'b0, 6'd3, 6'd0, 32'h0000_0012);
    send_edge(1'b0, 6'd1, 6'd2, 32'h0000_0013);
    send_edge(1'b0, 6'd2, 6'd3, 32'h0000_0014);
    send_edge(1'b0, 6'd0, 6'd1, 32'h0000_0015);   // tree already complete
    set_node_count(7'd0);
    send_edge(1'b1, 6'd0, 6'd0, 32'h0000_0001);
    send_edge(1'b0, 6'd0, 6'd1, 32'h0000_0002);
    set_node_count(7'd1);
    send_edge(1'b1, 6'd0, 6'd1, 32'h0000_0003);
    set_node_count(7'd127);
    send_edge(1'b1, 6'd63, 6'd0, 32'hFFFF_FFFF);
    set_node_count(7'd2);
    send_edge(1'b1, 6'd1, 6'd0, 32'h0000_0100);
    send_edge(1'b0, 6'd0, 6'd1, 32'h0000_0200);
    set_node_count(7'd65);
    send_edge(1'b1, 6'd63, 6'd32, 32'h0000_0300);
  endtask

  // node count lowered below what has already been accepted
  task automatic test_shrink_after_build();
    set_node_count(7'd64);
    send_edge(1'b1, 6'd0, 6'd1, 32'h0000_0001);
    send_edge(1'b0, 6'd1, 6'd2, 32'h0000_0002);
    send_edge(1'b0, 6'd2, 6'd3, 32'h0000_0003);
    set_node_count(7'd3);
    send_edge(1'b0, 6'd0, 6'd4, 32'h0000_0004);
    set_node_count(7'd64);
    send_edge(1'b0, 6'd4, 6'd5, 32'h0000_0005);
  endtask

  // receiver holds off while edges keep coming, so the input side stalls
  task automatic test_backpressure();
    int i;
    wait_for_quiet();
    rx_hold = HOLD_CYCLES;
    tx_rush = 1'b1;
    for (i = 0; i < 30; i++)
      send_edge(i == 0, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), $urandom);
    tx_rush = 1'b0;
    wait_for_quiet();
  endtask

  // well-formed spanning sequences with random content, plus noise edges
  task automatic test_random_graphs(int target);
    int n, graph, i, k, chain, tail, sel, rnd_sent;
    logic [NODE_W-1:0] order [64];
    logic [NODE_W-1:0] a, b, t;
    logic [WEIGHT_W-1:0] w;
    bit wide_w;
    graph = 0;
    rnd_sent = 0;
    while (rnd_sent < target) begin
      if (graph % 3 == 0) begin
        sel = $urandom_range(0, 19);
        if (sel < 14) set_node_count(CFG_W'($urandom_range(2, 12)));
        else if (sel < 17) set_node_count(CFG_W'($urandom_range(13, 64)));
        else if (sel < 18) set_node_count(7'd64);
        else set_node_count(CFG_W'($urandom_range(0, 127)));
      end
      n = live_nodes();
      foreach (order[j]) order[j] = NODE_W'(j);
      for (i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        t = order[i];
        order[i] = order[k];
        order[k] = t;
      end
      wide_w = ($urandom_range(0, 3) == 0);
      w = $urandom_range(0, 1000);
      chain = 1;
      tail = $urandom_range(1, 3);
      i = 0;
      while (chain < n || tail > 0) begin
        sel = $urandom_range(0, 99);
        if (chain < n && sel >= 25) begin
          a = order[chain];
          b = order[$urandom_range(0, chain - 1)];
          chain++;
        end else if (sel < 8) begin
          a = NODE_W'($urandom_range(0, 63));
          b = NODE_W'($urandom_range(0, 63));
        end else begin
          a = NODE_W'($urandom_range(0, n - 1));
          b = NODE_W'($urandom_range(0, n - 1));
          if (chain >= n) tail--;
        end
        if ($urandom_range(0, 1)) begin
          t = a;
          a = b;
          b = t;
        end
        w = wide_w ? $urandom : w + $urandom_range(0, 1 << 18);
        send_edge(i == 0 || $urandom_range(0, 99) < 2, a, b, w);
        i++;
        rnd_sent++;
      end
      graph++;
    end
  endtask

  initial begin
    cfg_nodes = NODE_COUNT_RESET;
    clear_forest();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_node_count_limits();
    test_shrink_after_build();
    test_backpressure();
    test_random_graphs(1200);
    wait_for_quiet();
    repeat (10) @(posedge clk);
    if (edge_verdicts.size() != 0) begin
      $display("%0d results never arrived", edge_verdicts.size());
      errors++;
    end
    $display("covered %0d edges over node counts 0..127: %0d joins, %0d trees completed",
             edges_sent, joins_seen, trees_done);
    $display("checked %0d results, %0d input stall cycles, %0d mismatches",
             results_seen, stall_cycles, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
